// ----- rtl/core/rsc_pkg.sv -----
`default_nettype none
package rsc_pkg;

  localparam int DEF_STACK_DEPTH = 16;
  localparam int QW              = 32;  // Q16.16 word
  localparam int FRAC            = 16;
  localparam int DVW             = QW + FRAC;  // dividend / quotient width

  localparam logic [2:0] FN_PUSH = 3'd0;
  localparam logic [2:0] FN_ADD  = 3'd1;
  localparam logic [2:0] FN_SUB  = 3'd2;
  localparam logic [2:0] FN_MUL  = 3'd3;
  localparam logic [2:0] FN_DIV  = 3'd4;
  localparam logic [2:0] FN_POP  = 3'd5;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNDER   = 2'd2,
    ST_DIVZERO = 2'd3
  } st_t;

  typedef enum logic [1:0] {
    VS_ZERO,
    VS_OPND,
    VS_RAM,
    VS_RES
  } vsel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_B,
    S_RD_A,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_WB,
    S_POP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]             func;
    logic signed [QW-1:0]   operand;
  } in_item_t;

  typedef struct packed {
    st_t                    status;
    logic signed [QW-1:0]   value;
    logic [4:0]             depth;
  } out_item_t;

  typedef struct packed {
    logic   load_in;
    logic   rd_top;
    logic   rd_second;
    logic   cap_b;
    logic   cap_a;
    logic   push_wr;
    logic   res_wr;
    logic   cnt_inc;
    logic   cnt_dec;
    logic   set_st;
    st_t    st;
    vsel_t  vsel;
    logic   mul_cap;
    logic   res_cap;
    logic   div_start;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       cnt_zero;
    logic       cnt_lt2;
    logic       cnt_full;
    logic       b_zero;
    logic       div_done;
    logic       out_busy;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/rsc_ram.sv -----
`default_nettype none
module rsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rsc_div.sv -----
`default_nettype none
// Restoring divider on magnitudes, one quotient bit per cycle.
module rsc_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rsc_pkg::DVW-1:0]     dividend,
  input  wire logic [rsc_pkg::QW-1:0]      divisor,
  output logic                             done,
  output logic      [rsc_pkg::DVW-1:0]     quotient
);

  localparam int CNTW = $clog2(rsc_pkg::DVW);

  logic [rsc_pkg::QW-1:0]  rem_r;
  logic [rsc_pkg::QW-1:0]  dsr_r;
  logic [rsc_pkg::DVW-1:0] quo_r;
  logic [CNTW-1:0]         cnt_r;
  logic                    busy_r;
  logic                    done_r;

  logic [rsc_pkg::QW:0]    shifted;
  logic [rsc_pkg::QW:0]    trial;

  assign shifted = {rem_r, quo_r[rsc_pkg::DVW-1]};
  assign trial   = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(rsc_pkg::DVW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dsr_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      // subtract when the shifted remainder covers the divisor
      if (!trial[rsc_pkg::QW]) begin
        rem_r <= trial[rsc_pkg::QW-1:0];
        quo_r <= {quo_r[rsc_pkg::DVW-2:0], 1'b1};
      end else begin
        rem_r <= shifted[rsc_pkg::QW-1:0];
        quo_r <= {quo_r[rsc_pkg::DVW-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ----- rtl/core/rsc_datapath.sv -----
`default_nettype none
module rsc_datapath #(
  parameter int STACK_DEPTH = rsc_pkg::DEF_STACK_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rsc_pkg::in_item_t   in_item,
  input  wire rsc_pkg::cmd_t       cmd,
  output rsc_pkg::sts_t            sts,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output rsc_pkg::out_item_t       out_item
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int QW = rsc_pkg::QW;

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  logic [2:0]             func_r;
  logic signed [QW-1:0]   opnd_r;
  logic signed [QW-1:0]   a_r;
  logic signed [QW-1:0]   b_r;
  logic signed [2*QW-1:0] prod_r;
  logic signed [QW-1:0]   result_r;
  logic                   div_neg_r;
  rsc_pkg::st_t           status_r;
  logic signed [QW-1:0]   value_r;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic                   out_valid_r;
  rsc_pkg::out_item_t     out_item_r;

  logic [CW-1:0]          cm1;
  logic [CW-1:0]          cm2;
  logic [QW-1:0]          rd_data;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [QW-1:0]          wr_data;
  logic [AW-1:0]          rd_addr;
  logic [CW+4:0]          cnt_ext;

  logic [QW:0]            sum;
  logic [QW:0]            diff;
  logic signed [2*QW-1:0] rnd;
  logic signed [2*QW-1:0] rsh;
  logic [QW-1:0]          a_abs;
  logic [QW-1:0]          b_abs;
  logic [rsc_pkg::DVW-1:0] quo;
  logic [rsc_pkg::DVW-1:0] quo_neg;
  logic                   div_done;
  logic signed [QW-1:0]   res_add;
  logic signed [QW-1:0]   res_sub;
  logic signed [QW-1:0]   res_mul;
  logic signed [QW-1:0]   res_div;
  logic signed [QW-1:0]   res_sel;

  function automatic logic signed [QW-1:0] sat33(input logic [QW:0] x);
    if (x[QW] != x[QW-1]) begin
      return x[QW] ? Q_MIN : Q_MAX;
    end
    return x[QW-1:0];
  endfunction

  assign cm1 = count_r - CW'(1);
  assign cm2 = count_r - CW'(2);

  // stack storage
  assign wr_en   = cmd.push_wr | cmd.res_wr;
  assign wr_addr = cmd.push_wr ? count_r[AW-1:0] : cm2[AW-1:0];
  assign wr_data = cmd.push_wr ? opnd_r : result_r;
  assign rd_addr = cmd.rd_second ? cm2[AW-1:0] : cm1[AW-1:0];

  rsc_ram #(
    .WIDTH (QW),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_top | cmd.rd_second),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // arithmetic
  assign sum     = {a_r[QW-1], a_r} + {b_r[QW-1], b_r};
  assign diff    = {a_r[QW-1], a_r} - {b_r[QW-1], b_r};
  assign res_add = sat33(sum);
  assign res_sub = sat33(diff);

  assign rnd = prod_r + (2*QW)'(32768);
  assign rsh = rnd >>> rsc_pkg::FRAC;
  always_comb begin
    if (!rsh[2*QW-1] && (|rsh[2*QW-2:QW-1])) begin
      res_mul = Q_MAX;
    end else if (rsh[2*QW-1] && !(&rsh[2*QW-2:QW-1])) begin
      res_mul = Q_MIN;
    end else begin
      res_mul = rsh[QW-1:0];
    end
  end

  assign a_abs = a_r[QW-1] ? QW'(-a_r) : a_r;
  assign b_abs = b_r[QW-1] ? QW'(-b_r) : b_r;

  rsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({a_abs, {rsc_pkg::FRAC{1'b0}}}),
    .divisor  (b_abs),
    .done     (div_done),
    .quotient (quo)
  );

  assign quo_neg = -quo;
  always_comb begin
    if (div_neg_r) begin
      if (quo > rsc_pkg::DVW'(Q_MIN[QW-1:0])) begin
        res_div = Q_MIN;
      end else begin
        res_div = quo_neg[QW-1:0];
      end
    end else begin
      if (quo > rsc_pkg::DVW'(Q_MAX[QW-1:0])) begin
        res_div = Q_MAX;
      end else begin
        res_div = quo[QW-1:0];
      end
    end
  end

  always_comb begin
    case (func_r)
      rsc_pkg::FN_ADD: res_sel = res_add;
      rsc_pkg::FN_SUB: res_sel = res_sub;
      rsc_pkg::FN_MUL: res_sel = res_mul;
      rsc_pkg::FN_DIV: res_sel = res_div;
      default:         res_sel = '0;
    endcase
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= in_item.func;
      opnd_r <= in_item.operand;
    end
    if (cmd.cap_b) begin
      b_r <= rd_data;
    end
    if (cmd.cap_a) begin
      a_r <= rd_data;
    end
    if (cmd.mul_cap) begin
      prod_r <= a_r * b_r;
    end
    if (cmd.div_start) begin
      div_neg_r <= a_r[QW-1] ^ b_r[QW-1];
    end
    if (cmd.res_cap) begin
      result_r <= res_sel;
    end
    if (cmd.set_st) begin
      status_r <= cmd.st;
      case (cmd.vsel)
        rsc_pkg::VS_OPND: value_r <= opnd_r;
        rsc_pkg::VS_RAM:  value_r <= rd_data;
        rsc_pkg::VS_RES:  value_r <= result_r;
        default:          value_r <= '0;
      endcase
    end
  end

  // stack count
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = cm1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // output register
  assign cnt_ext = {5'd0, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.status <= status_r;
      out_item_r.value  <= value_r;
      out_item_r.depth  <= cnt_ext[4:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign sts.func     = func_r;
  assign sts.cnt_zero = (count_r == '0);
  assign sts.cnt_lt2  = (count_r < CW'(2));
  assign sts.cnt_full = (count_r >= CW'(STACK_DEPTH));
  assign sts.b_zero   = (b_r == '0);
  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r & ~out_ready;

endmodule
`default_nettype wire

// ----- rtl/core/rsc_ctrl.sv -----
`default_nettype none
module rsc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rsc_pkg::sts_t  sts,
  output rsc_pkg::cmd_t       cmd
);

  rsc_pkg::state_t state_r;
  rsc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsc_pkg::S_IDLE: begin
        if (in_valid) state_nxt = rsc_pkg::S_DECODE;
      end
      rsc_pkg::S_DECODE: begin
        case (sts.func)
          rsc_pkg::FN_ADD, rsc_pkg::FN_SUB, rsc_pkg::FN_MUL, rsc_pkg::FN_DIV: begin
            state_nxt = sts.cnt_lt2 ? rsc_pkg::S_OUT : rsc_pkg::S_RD_B;
          end
          rsc_pkg::FN_POP: begin
            state_nxt = sts.cnt_zero ? rsc_pkg::S_OUT : rsc_pkg::S_POP;
          end
          default: state_nxt = rsc_pkg::S_OUT;
        endcase
      end
      rsc_pkg::S_RD_B: state_nxt = rsc_pkg::S_RD_A;
      rsc_pkg::S_RD_A: state_nxt = rsc_pkg::S_EXEC;
      rsc_pkg::S_EXEC: begin
        case (sts.func)
          rsc_pkg::FN_MUL: state_nxt = rsc_pkg::S_MUL;
          rsc_pkg::FN_DIV: state_nxt = sts.b_zero ? rsc_pkg::S_OUT : rsc_pkg::S_DIV;
          default:         state_nxt = rsc_pkg::S_WB;
        endcase
      end
      rsc_pkg::S_MUL: state_nxt = rsc_pkg::S_WB;
      rsc_pkg::S_DIV: begin
        if (sts.div_done) state_nxt = rsc_pkg::S_WB;
      end
      rsc_pkg::S_WB:  state_nxt = rsc_pkg::S_OUT;
      rsc_pkg::S_POP: state_nxt = rsc_pkg::S_OUT;
      rsc_pkg::S_OUT: begin
        if (!sts.out_busy) state_nxt = rsc_pkg::S_IDLE;
      end
      default: state_nxt = rsc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.st   = rsc_pkg::ST_OK;
    cmd.vsel = rsc_pkg::VS_ZERO;
    in_ready = 1'b0;
    case (state_r)
      rsc_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      rsc_pkg::S_DECODE: begin
        case (sts.func)
          rsc_pkg::FN_PUSH: begin
            cmd.set_st = 1'b1;
            if (sts.cnt_full) begin
              cmd.st = rsc_pkg::ST_FULL;
            end else begin
              cmd.push_wr = 1'b1;
              cmd.cnt_inc = 1'b1;
              cmd.vsel    = rsc_pkg::VS_OPND;
            end
          end
          rsc_pkg::FN_ADD, rsc_pkg::FN_SUB, rsc_pkg::FN_MUL, rsc_pkg::FN_DIV: begin
            if (sts.cnt_lt2) begin
              cmd.set_st = 1'b1;
              cmd.st     = rsc_pkg::ST_UNDER;
            end else begin
              cmd.rd_top = 1'b1;
            end
          end
          rsc_pkg::FN_POP: begin
            if (sts.cnt_zero) begin
              cmd.set_st = 1'b1;
              cmd.st     = rsc_pkg::ST_UNDER;
            end else begin
              cmd.rd_top = 1'b1;
            end
          end
          default: cmd.set_st = 1'b1;
        endcase
      end
      rsc_pkg::S_RD_B: begin
        cmd.cap_b     = 1'b1;
        cmd.rd_second = 1'b1;
      end
      rsc_pkg::S_RD_A: cmd.cap_a = 1'b1;
      rsc_pkg::S_EXEC: begin
        case (sts.func)
          rsc_pkg::FN_MUL: cmd.mul_cap = 1'b1;
          rsc_pkg::FN_DIV: begin
            if (sts.b_zero) begin
              cmd.cnt_dec = 1'b1;
              cmd.set_st  = 1'b1;
              cmd.st      = rsc_pkg::ST_DIVZERO;
            end else begin
              cmd.div_start = 1'b1;
            end
          end
          default: cmd.res_cap = 1'b1;
        endcase
      end
      rsc_pkg::S_MUL: cmd.res_cap = 1'b1;
      rsc_pkg::S_DIV: cmd.res_cap = sts.div_done;
      rsc_pkg::S_WB: begin
        cmd.res_wr  = 1'b1;
        cmd.cnt_dec = 1'b1;
        cmd.set_st  = 1'b1;
        cmd.vsel    = rsc_pkg::VS_RES;
      end
      rsc_pkg::S_POP: begin
        cmd.cnt_dec = 1'b1;
        cmd.set_st  = 1'b1;
        cmd.vsel    = rsc_pkg::VS_RAM;
      end
      rsc_pkg::S_OUT: cmd.out_load = ~sts.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/rpn_stack_calculator.sv -----
`default_nettype none
// Items are handled one at a time; the next item is accepted once the previous
// result has entered the output register, even while that result waits.
// Reset (rst_n low, synchronous) empties the stack and drops any pending result;
// stack RAM contents are not cleared, entries above the depth are never read.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rsc_pkg::DEF_STACK_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rsc_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rsc_pkg::out_item_t       out_item
);

  // command and status bundles between the sequencer and the datapath
  rsc_pkg::cmd_t cmd;
  rsc_pkg::sts_t sts;

  // sequence each item: decode, read the top entries, compute, write back,
  // then hand the result to the output register
  rsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold the stack RAM, the depth counter, the arithmetic units and the
  // output register
  rsc_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ----- test/rpn_stack_calculator_test.sv -----
`default_nettype none
module rpn_stack_calculator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rsc_pkg::*;

  localparam int STACK_DEPTH = DEF_STACK_DEPTH;
  // Longest quiet stretch of a correct run: a divide plus a long receiver
  // stall at 86 percent idling stays far below this.
  localparam int STALL_LIMIT = 3000;
  // Settle time after the last result; covers the slowest operation.
  localparam int TAIL_CYCLES = 100;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  rpn_stack_calculator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // Percent of cycles in which each side holds back.
  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;

  // Calculator state as seen by the predictor.
  logic signed [QW-1:0] calc_stack [STACK_DEPTH];
  int                   calc_depth = 0;

  // Expected results, oldest first.
  out_item_t pending_results[$];

  int mismatch_count = 0;
  int stall_cycles = 0;
  int func_seen [8];
  int status_seen [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold reset at the start, then release it once for the whole run.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Receiver: drop ready at random in out_idle_pct percent of the cycles.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Compute the result of one item and advance the predicted stack.
  function automatic out_item_t predict_calc(in_item_t it);
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] wide;
    out_item_t          r;
    r.status = ST_OK;
    r.value  = '0;
    case (it.func)
      FN_PUSH: begin
        if (calc_depth < STACK_DEPTH) begin
          calc_stack[calc_depth] = it.operand;
          calc_depth++;
          r.value = it.operand;
        end else begin
          r.status = ST_FULL;
        end
      end
      FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
        if (calc_depth < 2) begin
          r.status = ST_UNDER;
        end else begin
          // A is second from top, B is the top entry.
          a = calc_stack[calc_depth-2];
          b = calc_stack[calc_depth-1];
          if (it.func == FN_DIV && b == 0) begin
            // Drop the zero divisor, keep the dividend on top.
            calc_depth--;
            r.status = ST_DIVZERO;
          end else begin
            case (it.func)
              FN_ADD:  wide = a + b;
              FN_SUB:  wide = a - b;
              // Round to nearest, ties up: add half an LSB, then floor.
              FN_MUL:  wide = (a * b + 64'sd32768) >>> 16;
              default: wide = (a <<< 16) / b;
            endcase
            if (wide > 64'sh7FFF_FFFF) begin
              r.value = 32'sh7FFF_FFFF;
            end else if (wide < -64'sh8000_0000) begin
              r.value = 32'sh8000_0000;
            end else begin
              r.value = wide[QW-1:0];
            end
            calc_depth--;
            calc_stack[calc_depth-1] = r.value;
          end
        end
      end
      FN_POP: begin
        if (calc_depth == 0) begin
          r.status = ST_UNDER;
        end else begin
          calc_depth--;
          r.value = calc_stack[calc_depth];
        end
      end
      default: ;  // unknown codes leave the stack alone
    endcase
    r.depth = calc_depth[4:0];
    return r;
  endfunction

  // Input side: predict every accepted item.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      pending_results.push_back(predict_calc(in_item));
      func_seen[in_item.func]++;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Output side: compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, value", out_item.value, '0);
      end else begin
        want = pending_results.pop_front();
        status_seen[want.status]++;
        if (out_item.status != want.status)
          report_mismatch("status", 32'(out_item.status), 32'(want.status));
        if (out_item.value != want.value)
          report_mismatch("value", out_item.value, want.value);
        if (out_item.depth != want.depth)
          report_mismatch("depth", 32'(out_item.depth), 32'(want.depth));
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  initial begin
    wait (rst_n);
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("ERROR: no item moved for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Send one item. Valid stays high on return so that a following item can
  // go out back to back; lower it only when idling or pausing.
  task automatic send_item(input logic [2:0] func, input logic [QW-1:0] operand);
    in_item_t it;
    it.func    = func;
    it.operand = operand;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      in_item  <= '{func: 3'($urandom), operand: $urandom};
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Pause the sender until every expected result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Operations on an empty and a one-deep stack, plus the unknown codes.
  task automatic test_underflow_and_unknown();
    send_item(FN_POP, $urandom);
    send_item(FN_ADD, $urandom);
    send_item(3'd6, $urandom);
    send_item(FN_PUSH, 32'h7FFF_FFFF);
    send_item(FN_DIV, $urandom);
    send_item(FN_SUB, $urandom);
    send_item(3'd7, $urandom);
  endtask

  // Fill the stack to the top, then push once more. The top entries are
  // laid out for the saturation and divide-by-zero cases that follow.
  task automatic test_full_stack();
    logic [QW-1:0] fill [15] = '{
      32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_8000, 32'hFFFF_8000,
      32'h0001_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000,
      32'h8000_0001,
      32'h7FFF_FFFF,   // add partner
      32'h7FFF_FFFF,   // subtract dividend side
      32'h8000_0000,   // multiply partner
      32'h8000_0000,   // divide dividend
      32'hFFFF_0000,   // -1.0
      32'h0000_0000    // zero divisor on top
    };
    foreach (fill[i]) send_item(FN_PUSH, fill[i]);
    send_item(FN_PUSH, 32'h1234_5678);
  endtask

  // Work down the full stack through each arithmetic corner.
  task automatic test_saturation_and_divzero();
    send_item(FN_DIV, $urandom);  // divide by zero
    send_item(FN_DIV, $urandom);  // most negative over -1.0 clamps high
    send_item(FN_MUL, $urandom);  // most negative times largest clamps low
    send_item(FN_SUB, $urandom);  // largest minus most negative clamps high
    send_item(FN_ADD, $urandom);  // largest plus largest clamps high
    send_item(FN_POP, $urandom);
    wait_for_results();
  endtask

  function automatic logic [QW-1:0] pick_operand();
    logic [QW-1:0] v;
    case ($urandom_range(9))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2:       v = '0;
      3:       v = $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4, 5: begin
        // Modest values keep most arithmetic out of saturation.
        v = $urandom_range(32'h0005_FFFF);
        if ($urandom_range(1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Random traffic in chunks that lean toward pushes or toward operations,
  // so the stack swings between empty and full. Unknown codes slip in as
  // noise and do not count toward the item total.
  task automatic test_random_traffic(input int unsigned send_idle, input int unsigned recv_idle,
                                     input int n_items);
    int          sent;
    int unsigned push_pct;
    int unsigned pick;
    in_idle_pct  = send_idle;
    out_idle_pct = recv_idle;
    sent         = 0;
    push_pct     = 65;
    while (sent < n_items) begin
      if (sent % 40 == 0) push_pct = (push_pct == 65) ? 25 : 65;
      if (sent % 120 == 119) wait_for_results();
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_item(3'($urandom_range(6, 7)), $urandom);
      end else begin
        if (pick < 3 + push_pct) begin
          send_item(FN_PUSH, pick_operand());
        end else begin
          send_item(3'($urandom_range(FN_ADD, FN_POP)), $urandom);
        end
        sent++;
      end
    end
    wait_for_results();
  endtask

  initial begin
    wait (rst_n);
    @(posedge clk);

    // Directed part with a slow receiver and a mildly idle sender.
    in_idle_pct  = 25;
    out_idle_pct = 86;
    test_underflow_and_unknown();
    test_full_stack();
    test_saturation_and_divzero();

    // Random part: swap which side idles, then run with no idling at all.
    test_random_traffic(25, 86, 310);
    test_random_traffic(86, 25, 310);
    test_random_traffic(0, 0, 310);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered, count", pending_results.size(), 0);

    $display("Run covered push %0d, add %0d, sub %0d, mul %0d, div %0d, pop %0d, unknown %0d",
             func_seen[FN_PUSH], func_seen[FN_ADD], func_seen[FN_SUB], func_seen[FN_MUL],
             func_seen[FN_DIV], func_seen[FN_POP], func_seen[6] + func_seen[7]);
    $display("Outcomes: ok %0d, full %0d, underflow %0d, divide by zero %0d; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_UNDER],
             status_seen[ST_DIVZERO], mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- rpn_stack_calculator.f -----
rtl/core/rsc_pkg.sv
rtl/core/rsc_ram.sv
rtl/core/rsc_div.sv
rtl/core/rsc_datapath.sv
rtl/core/rsc_ctrl.sv
rtl/core/rpn_stack_calculator.sv
test/rpn_stack_calculator_test.sv
